// ----- rtl/bb13_pkg.sv -----
// Shared types, constants and helpers of the 13x13 box blur.
package bb13_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int Radius    = 6;
  localparam int Span      = 2 * Radius + 1;

  localparam int COL_W   = 10;  // column counter, 0..MaxWidth-1
  localparam int ROW_W   = 13;  // row counter, reaches MaxHeight when input done
  localparam int RING_W  = 4;   // ring row, 0..Span-1
  localparam int WCFG_W  = 11;
  localparam int HCFG_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int LS_AW    = RING_W + COL_W;
  localparam int LS_DEPTH = Span * MaxWidth;
  localparam int LAG_W    = 13;  // fill count, up to Radius*MaxWidth+Radius

  localparam int CSUM_W = 12;   // 13 rows of 8 bits
  localparam int HSUM_W = 16;   // 169 pixels of 8 bits
  localparam int RECIP_SHIFT = 23;
  localparam logic [15:0] RECIP = 16'd49637;  // ceil(2^23 / 169)

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  typedef logic [2:0][CSUM_W-1:0] csum_t;
  typedef logic [2:0][HSUM_W-1:0] hsum_t;

  typedef struct packed {
    logic  frame_last;
    pix_t  pix;
  } res_t;

  // Window sum / 169 by reciprocal multiply, exact for sums up to 169*255.
  function automatic chan_t div169(input logic [HSUM_W-1:0] s);
    logic [31:0] prod;
    prod = s * RECIP;
    return prod[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

// ----- rtl/bb13_in_if.sv -----
// Input pixel channel: valid/ready with one RGB pixel or a flush marker.
interface bb13_in_if;
  logic                 valid;
  logic                 ready;
  bb13_pkg::chan_t      blue_in;
  bb13_pkg::chan_t      green_in;
  bb13_pkg::chan_t      red_in;
  logic                 flush;

  modport source (output valid, blue_in, green_in, red_in, flush, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, flush, output ready);
endinterface

// ----- rtl/bb13_out_if.sv -----
// Result pixel channel: valid/ready with one RGB pixel and an end-of-frame mark.
interface bb13_out_if;
  logic                 valid;
  logic                 ready;
  bb13_pkg::chan_t      blue_out;
  bb13_pkg::chan_t      green_out;
  bb13_pkg::chan_t      red_out;
  logic                 frame_last;

  modport source (output valid, blue_out, green_out, red_out, frame_last, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, frame_last, output ready);
endinterface

// ----- rtl/box_blur_13x13_rgb.sv -----
// Streaming 13x13 box blur of an RGB frame, line store and column sums in RAM.
//
//   channel | dir | handshake      | word
//   in_ch   | in  | valid/ready    | blue_in, green_in, red_in, flush
//   out_ch  | out | valid/ready    | blue_out, green_out, red_out, frame_last
//   cfg     | in  | cfg_we         | cfg_idx, cfg_wdata
//
// One word per clock while in_ch.ready is high; a result leaves the 4-deep output
// queue after its word passes the RAM read, column/row sum and divide stages.
// in_ch.ready drops only when the output queue plus words in flight fill it.
// rst_n is synchronous; RAM contents are not cleared (column sums restart on
// row 0 of each frame). A register write restarts the frame.
module box_blur_13x13_rgb (
  input  logic clk,
  input  logic rst_n,
  bb13_in_if.sink    in_ch,
  bb13_out_if.source out_ch,
  input  logic                               cfg_we,
  input  logic [bb13_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bb13_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int COL_W  = bb13_pkg::COL_W;
  localparam int ROW_W  = bb13_pkg::ROW_W;
  localparam int RING_W = bb13_pkg::RING_W;

  // Configuration
  logic [bb13_pkg::WCFG_W-1:0] width_r;
  logic [bb13_pkg::HCFG_W-1:0] height_r;
  logic [bb13_pkg::WCFG_W-1:0] w_eff;
  logic [ROW_W-1:0]            h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bb13_pkg::WIDTH_RESET;
      height_r <= bb13_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        bb13_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[bb13_pkg::WCFG_W-1:0];
        bb13_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[bb13_pkg::HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to 1..max
  always_comb begin
    if (width_r == '0) w_eff = bb13_pkg::WCFG_W'(1);
    else if (width_r > bb13_pkg::WCFG_W'(bb13_pkg::MaxWidth))
      w_eff = bb13_pkg::WCFG_W'(bb13_pkg::MaxWidth);
    else w_eff = width_r;
    if (height_r == '0) h_eff = ROW_W'(1);
    else if (height_r > ROW_W'(bb13_pkg::MaxHeight)) h_eff = ROW_W'(bb13_pkg::MaxHeight);
    else h_eff = height_r;
  end

  // Position counters
  logic [COL_W-1:0]  in_col_r, out_col_r, in_col_nxt, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, out_row_r, in_row_nxt, out_row_nxt;
  logic [RING_W-1:0] in_ring_r, out_ring_r, in_ring_nxt, out_ring_nxt;
  logic [bb13_pkg::LAG_W-1:0] lag, fill_r, fill_nxt, cur_fill;

  logic in_done, accept, take_pix, take_flush, pix_emit, emit, inner, last;
  logic [COL_W-1:0]  cur_col, o_col;
  logic [ROW_W-1:0]  cur_row, o_row;
  logic [RING_W-1:0] cur_ring, o_ring;
  logic col_end, o_col_end;

  assign in_done = in_row_r >= h_eff;
  assign accept  = in_ch.valid & in_ch.ready;
  assign take_pix   = accept & ~in_ch.flush;
  assign take_flush = accept & in_ch.flush & in_done & (out_row_r < h_eff);

  // A pixel after a finished frame starts a new one at the origin
  always_comb begin
    if (in_done && take_pix) begin
      cur_col = '0; cur_row = '0; cur_ring = '0;
      o_col = '0;   o_row = '0;   o_ring = '0;
      cur_fill = '0;
    end else begin
      cur_col = in_col_r;  cur_row = in_row_r;  cur_ring = in_ring_r;
      o_col = out_col_r;   o_row = out_row_r;   o_ring = out_ring_r;
      cur_fill = fill_r;
    end
  end

  // Pixels taken before the first result: Radius rows plus Radius pixels
  assign lag = bb13_pkg::LAG_W'(w_eff) * bb13_pkg::LAG_W'(bb13_pkg::Radius)
             + bb13_pkg::LAG_W'(bb13_pkg::Radius);
  assign pix_emit = cur_fill >= lag;
  assign emit  = take_flush | (take_pix & pix_emit);
  assign inner = take_pix && (cur_row >= ROW_W'(2 * bb13_pkg::Radius)) &&
                 (cur_col >= COL_W'(2 * bb13_pkg::Radius));
  assign col_end   = {1'b0, cur_col} == (w_eff - 1'b1);
  assign o_col_end = {1'b0, o_col} == (w_eff - 1'b1);
  assign last      = (o_row == (h_eff - 1'b1)) && o_col_end;

  always_comb begin
    in_col_nxt = in_col_r;   in_row_nxt = in_row_r;   in_ring_nxt = in_ring_r;
    out_col_nxt = out_col_r; out_row_nxt = out_row_r; out_ring_nxt = out_ring_r;
    fill_nxt = fill_r;
    if (cfg_we) begin
      in_col_nxt = '0;  in_row_nxt = '0;  in_ring_nxt = '0;
      out_col_nxt = '0; out_row_nxt = '0; out_ring_nxt = '0;
      fill_nxt = '0;
    end else if (take_pix || take_flush) begin
      if (take_pix) begin
        in_col_nxt = col_end ? '0 : cur_col + 1'b1;
        in_row_nxt = col_end ? cur_row + 1'b1 : cur_row;
        if (col_end)
          in_ring_nxt = (cur_ring == RING_W'(bb13_pkg::Span - 1)) ? '0 : cur_ring + 1'b1;
        else
          in_ring_nxt = cur_ring;
        // saturates once the lag is filled
        fill_nxt = (cur_fill < lag) ? cur_fill + 1'b1 : cur_fill;
      end
      out_col_nxt = o_col; out_row_nxt = o_row; out_ring_nxt = o_ring;
      if (emit) begin
        out_col_nxt = o_col_end ? '0 : o_col + 1'b1;
        if (o_col_end) begin
          out_row_nxt  = o_row + 1'b1;
          out_ring_nxt = (o_ring == RING_W'(bb13_pkg::Span - 1)) ? '0 : o_ring + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;  in_row_r <= '0;  in_ring_r <= '0;
      out_col_r <= '0; out_row_r <= '0; out_ring_r <= '0;
      fill_r <= '0;
    end else begin
      in_col_r <= in_col_nxt;   in_row_r <= in_row_nxt;   in_ring_r <= in_ring_nxt;
      out_col_r <= out_col_nxt; out_row_r <= out_row_nxt; out_ring_r <= out_ring_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Line store: 13-row ring, old word read at the write address before overwrite
  bb13_pkg::pix_t ls_mem [bb13_pkg::LS_DEPTH];
  bb13_pkg::pix_t ls_old_r, ls_pass_r, in_pix;
  logic [bb13_pkg::LS_AW-1:0] ls_wa, ls_ra;

  assign in_pix = '{red: in_ch.red_in, green: in_ch.green_in, blue: in_ch.blue_in};
  assign ls_wa  = {cur_ring, cur_col};
  assign ls_ra  = {o_ring, o_col};

  always_ff @(posedge clk) begin
    if (accept) begin
      ls_old_r  <= ls_mem[ls_wa];
      ls_pass_r <= ls_mem[ls_ra];
    end
    if (take_pix) ls_mem[ls_wa] <= in_pix;
  end

  // Column sums: read on accept, written back in the next cycle
  bb13_pkg::csum_t cs_mem [bb13_pkg::MaxWidth];
  bb13_pkg::csum_t cs_rd_r, col_new, col_base, s2_col_r;

  // Stage 1 control
  logic s1_pix_r, s1_emit_r, s1_inner_r, s1_last_r;
  logic s1_first_r, s1_sub_r, s1_hsub_r, s1_hzero_r, s1_fwd_r;
  logic [COL_W-1:0] s1_x_r;
  bb13_pkg::pix_t   s1_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r <= 1'b0; s1_emit_r <= 1'b0; s1_inner_r <= 1'b0; s1_fwd_r <= 1'b0;
    end else begin
      s1_pix_r   <= take_pix;
      s1_emit_r  <= emit;
      s1_inner_r <= inner;
      // previous pixel at the same column is still being written back
      s1_fwd_r   <= take_pix && s1_pix_r && (s1_x_r == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cs_rd_r    <= cs_mem[cur_col];
      s1_last_r  <= last;
      s1_x_r     <= cur_col;
      s1_rgb_r   <= in_pix;
      s1_first_r <= cur_row == '0;
      s1_sub_r   <= cur_row >= ROW_W'(bb13_pkg::Span);
      s1_hsub_r  <= cur_col >= COL_W'(bb13_pkg::Span);
      s1_hzero_r <= cur_col == '0;
    end
    if (s1_pix_r) cs_mem[s1_x_r] <= col_new;
  end

  // Vertical and horizontal sliding sums
  bb13_pkg::csum_t taps_r [bb13_pkg::Span];
  bb13_pkg::hsum_t hsum_r, hsum_nxt;
  bb13_pkg::pix_t  old_pix;

  assign old_pix  = s1_sub_r ? ls_old_r : '0;
  assign col_base = s1_first_r ? '0 : (s1_fwd_r ? s2_col_r : cs_rd_r);

  always_comb begin
    col_new[0] = col_base[0] + bb13_pkg::CSUM_W'(s1_rgb_r.blue)
               - bb13_pkg::CSUM_W'(old_pix.blue);
    col_new[1] = col_base[1] + bb13_pkg::CSUM_W'(s1_rgb_r.green)
               - bb13_pkg::CSUM_W'(old_pix.green);
    col_new[2] = col_base[2] + bb13_pkg::CSUM_W'(s1_rgb_r.red)
               - bb13_pkg::CSUM_W'(old_pix.red);
    for (int k = 0; k < 3; k++) begin
      hsum_nxt[k] = (s1_hzero_r ? '0 : hsum_r[k]) + bb13_pkg::HSUM_W'(col_new[k])
                  - (s1_hsub_r ? bb13_pkg::HSUM_W'(taps_r[bb13_pkg::Span-1][k])
                               : bb13_pkg::HSUM_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (s1_pix_r) begin
      hsum_r    <= hsum_nxt;
      s2_col_r  <= col_new;
      taps_r[0] <= col_new;
      for (int i = 1; i < bb13_pkg::Span; i++) taps_r[i] <= taps_r[i-1];
    end
  end

  // Stage 2: divide or pass, then queue
  logic s2_emit_r, s2_inner_r, s2_last_r;
  bb13_pkg::pix_t s2_pass_r;
  bb13_pkg::res_t s2_res;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_emit_r <= 1'b0;
    else        s2_emit_r <= s1_emit_r;
    s2_inner_r <= s1_inner_r;
    s2_last_r  <= s1_last_r;
    s2_pass_r  <= ls_pass_r;
  end

  always_comb begin
    s2_res.frame_last = s2_last_r;
    if (s2_inner_r) begin
      s2_res.pix.blue  = bb13_pkg::div169(hsum_r[0]);
      s2_res.pix.green = bb13_pkg::div169(hsum_r[1]);
      s2_res.pix.red   = bb13_pkg::div169(hsum_r[2]);
    end else begin
      s2_res.pix = s2_pass_r;
    end
  end

  // Output queue
  bb13_pkg::res_t fifo_mem [bb13_pkg::FIFO_DEPTH];
  logic [bb13_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  logic [bb13_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt, load;
  logic push, pop;
  bb13_pkg::res_t head;

  assign push = s2_emit_r;
  assign pop  = out_ch.valid & out_ch.ready;
  assign load = cnt_r + bb13_pkg::FIFO_CW'(s1_emit_r) + bb13_pkg::FIFO_CW'(s2_emit_r);
  assign in_ch.ready = load < bb13_pkg::FIFO_CW'(bb13_pkg::FIFO_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0; rptr_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wptr_r] <= s2_res;
  end

  assign head              = fifo_mem[rptr_r];
  assign out_ch.valid      = cnt_r != '0;
  assign out_ch.blue_out   = head.pix.blue;
  assign out_ch.green_out  = head.pix.green;
  assign out_ch.red_out    = head.pix.red;
  assign out_ch.frame_last = head.frame_last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bb13_pkg::FIFO_CW'(bb13_pkg::FIFO_DEPTH))
    else $error("output queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < bb13_pkg::FIFO_CW'(bb13_pkg::FIFO_DEPTH)) || pop)
    else $error("push into full queue");
  a_inner_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_inner_r |-> (s1_pix_r && s1_emit_r))
    else $error("window result without pixel");
  a_fwd_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> (s1_pix_r && $past(s1_pix_r)))
    else $error("column forward without writer");
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (in_row_r == '0) && (out_row_r == '0))
    else $error("config write did not restart frame");
`endif

endmodule

// ----- test/box_blur_13x13_rgb_tb.sv -----
// Self-checking testbench for the 13x13 RGB box blur: random frames, flushes and handshake gaps.
module box_blur_13x13_rgb_tb;
  import bb13_pkg::*;

  // Scoreboard: mirrors the blur and keeps the queue of pixels still owed by the block
  class blur_scoreboard;
    pix_t        ring_rows[Span * MaxWidth];
    int unsigned width_reg, height_reg;
    int unsigned in_row, in_col, out_row, out_col;
    res_t        owed_pixels[$];
    int          errors;

    function new();
      width_reg  = 640;
      height_reg = 480;
      errors     = 0;
      restart();
    endfunction

    // results already produced stay owed; only positions restart
    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      if (idx == CFG_IMAGE_WIDTH) width_reg = val & 'h7ff;
      else height_reg = val & 'h1fff;
      restart();
    endfunction

    // Output pixel at the current output position, then advance
    function void emit_pixel(int unsigned w, int unsigned h);
      res_t        res;
      int unsigned sb, sg, sr;
      pix_t        p;
      sb = 0; sg = 0; sr = 0;
      if (out_row >= Radius && out_row + Radius < h &&
          out_col >= Radius && out_col + Radius < w) begin
        for (int unsigned i = out_row - Radius; i <= out_row + Radius; i++)
          for (int unsigned j = out_col - Radius; j <= out_col + Radius; j++) begin
            p = ring_rows[(i % Span) * MaxWidth + j];
            sb += p.blue; sg += p.green; sr += p.red;
          end
        res.pix.blue  = chan_t'(sb / (Span * Span));
        res.pix.green = chan_t'(sg / (Span * Span));
        res.pix.red   = chan_t'(sr / (Span * Span));
      end else begin
        res.pix = ring_rows[(out_row % Span) * MaxWidth + out_col];
      end
      res.frame_last = (out_row == h - 1 && out_col == w - 1);
      owed_pixels.push_back(res);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    endfunction

    function void note_word(logic flush, pix_t p);
      int unsigned w, h;
      w = eff_w();
      h = eff_h();
      if (flush) begin
        if (in_row >= h && out_row < h) emit_pixel(w, h);
        return;
      end
      // a pixel after a finished frame opens a new one, dropping what is pending
      if (in_row >= h) restart();
      ring_rows[(in_row % Span) * MaxWidth + in_col] = p;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (in_row * w + in_col > Radius * w + Radius && out_row < h) emit_pixel(w, h);
    endfunction

    function void check_pixel(res_t got);
      res_t exp;
      if (owed_pixels.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp = owed_pixels.pop_front();
      if (got.pix.red !== exp.pix.red) begin
        $display("%0t: red_out exp %0d got %0d", $time, exp.pix.red, got.pix.red);
        errors++;
      end
      if (got.pix.green !== exp.pix.green) begin
        $display("%0t: green_out exp %0d got %0d", $time, exp.pix.green, got.pix.green);
        errors++;
      end
      if (got.pix.blue !== exp.pix.blue) begin
        $display("%0t: blue_out exp %0d got %0d", $time, exp.pix.blue, got.pix.blue);
        errors++;
      end
      if (got.frame_last !== exp.frame_last) begin
        $display("%0t: frame_last exp %0b got %0b", $time, exp.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  bit   calm = 0;
  int   out_stall = 0;
  int   sent_words = 0;

  blur_scoreboard sb = new();

  bb13_in_if  in_ch();
  bb13_out_if out_ch();

  box_blur_13x13_rgb dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0; in_ch.flush = 0;
    in_ch.blue_in = 0; in_ch.green_in = 0; in_ch.red_in = 0;
    out_ch.ready = 0;
  end

  // Sink side: random back-pressure, mostly short
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready <= 0;
      out_stall--;
    end else begin
      out_ch.ready <= 1;
      if (!calm) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) out_stall = $urandom_range(1, 3);
        else if (pick == 12) out_stall = $urandom_range(15, 50);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pixel({out_ch.frame_last, out_ch.red_out, out_ch.green_out, out_ch.blue_out});
  end

  // One word on the input channel, with a random gap ahead of it
  task automatic send_word(logic flush, pix_t p);
    int gap, pick;
    gap = 0;
    if (!calm) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) gap = $urandom_range(1, 3);
      else if (pick < 22) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1;
    in_ch.flush    <= flush;
    in_ch.blue_in  <= p.blue;
    in_ch.green_in <= p.green;
    in_ch.red_in   <= p.red;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(flush, p);
    sent_words++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 0;
    while (sb.owed_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_frame(int unsigned wv, int unsigned hv);
    wait_idle();
    cfg_we <= 1; cfg_idx <= CFG_IMAGE_WIDTH; cfg_wdata <= CFG_DATA_W'(wv);
    @(posedge clk);
    sb.write_reg(CFG_IMAGE_WIDTH, wv);
    cfg_idx <= CFG_IMAGE_HEIGHT; cfg_wdata <= CFG_DATA_W'(hv);
    @(posedge clk);
    sb.write_reg(CFG_IMAGE_HEIGHT, hv);
    cfg_we <= 0;
  endtask

  // Random pixel; mode 1 all white, mode 2 all black
  function automatic pix_t rand_pix(int mode);
    pix_t p;
    if (mode == 1) p = '1;
    else if (mode == 2) p = '0;
    else p = pix_t'($urandom);
    return p;
  endfunction

  // Whole frame: pixels with stray flushes, then drain flushes (maybe cut short)
  task automatic run_frame(int mode, bit cut_short);
    int unsigned w, h, drain;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int unsigned k = 0; k < w * h; k++) begin
      if ($urandom_range(0, 99) < 4) send_word(1, rand_pix(0));
      send_word(0, rand_pix(mode));
    end
    drain = Radius * w + Radius + $urandom_range(0, 3);
    if (cut_short) drain = $urandom_range(0, drain / 2);
    repeat (drain) send_word(1, rand_pix(0));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes of size and pixel values
    set_frame(13, 13);  run_frame(1, 0);
    set_frame(14, 13);  run_frame(2, 0);
    set_frame(0, 0);    run_frame(0, 0);
    // oversized registers: start a frame, then restart it by a write
    set_frame(1, 8191); repeat (40) send_word(0, rand_pix(0));
    set_frame(2047, 1); repeat (40) send_word(0, rand_pix(0));
    set_frame(20, 4);   run_frame(0, 1);
    run_frame(0, 0);

    // random frames, mostly big enough to have a blurred core
    while (sent_words < 1700) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 4) == 0)
          set_frame($urandom_range(1, 12), $urandom_range(1, 14));
        else
          set_frame($urandom_range(13, 30), $urandom_range(13, 18));
      end
      run_frame($urandom_range(0, 9) == 0 ? 1 : 0, $urandom_range(0, 7) == 0);
    end
    calm = 0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sb.owed_pixels.size() != 0)
        $display("%0t: %0d pixels never arrived", $time, sb.owed_pixels.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(100_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bb13_pkg.sv
rtl/bb13_in_if.sv
rtl/bb13_out_if.sv
rtl/box_blur_13x13_rgb.sv
test/box_blur_13x13_rgb_tb.sv
